// ===== sv/stlf_pkg.sv =====
// stlf_pkg: shared types, codes and constants of the short-term lattice filter
// holds the log-area ratio to reflection coefficient mapping
// no dependencies
`default_nettype none

package stlf_pkg;

    localparam int DEF_ORDER      = 8;
    localparam int DEF_DATA_WIDTH = 16;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int STAGE_W   = 3;
    localparam int COEF_W    = 16;
    localparam int FRAC_BITS = 15;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic MODE_ANALYSIS  = 1'b0;
    localparam logic MODE_SYNTHESIS = 1'b1;

    // knees and offsets of the three-piece mapping, lar in Q13, coefficient in Q15
    localparam logic [16:0] LAR_KNEE1   = 17'd5530;
    localparam logic [16:0] LAR_KNEE2   = 17'd10036;
    localparam logic [16:0] OFFSET_MID  = 17'd11059;
    localparam logic [16:0] OFFSET_HIGH = 17'd26112;
    localparam logic [16:0] POS_LIMIT   = 17'd32767;
    localparam logic [16:0] NEG_LIMIT   = 17'd32768;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } state_t;

    // operand pairing of the shared multiplier
    typedef enum logic [1:0] {
        MK_NONE,
        MK_DELAY,
        MK_ACC
    } mul_kind_t;

    function automatic logic signed [COEF_W-1:0] lar_to_coeff(
        input logic signed [IN_W-1:0] lar
    );
        logic [16:0] mag;
        logic [16:0] m;
        logic [16:0] neg;
        mag = lar[IN_W-1] ? (~{lar[IN_W-1], lar} + 17'd1) : {1'b0, lar};
        if (mag < LAR_KNEE1) begin
            m = mag << 2;
        end else if (mag < LAR_KNEE2) begin
            m = (mag << 1) + OFFSET_MID;
        end else begin
            m = (mag >> 1) + OFFSET_HIGH;
        end
        neg = ~m + 17'd1;
        if (!lar[IN_W-1]) begin
            return (m > POS_LIMIT) ? POS_LIMIT[COEF_W-1:0] : m[COEF_W-1:0];
        end
        return (m > NEG_LIMIT) ? NEG_LIMIT[COEF_W-1:0] : neg[COEF_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/short_term_lattice_filter_unit.sv =====
// short_term_lattice_filter_unit: lattice filter top level with one shared multiplier
// depends on stlf_pkg
`default_nettype none

// Short-term lattice filter of ORDER stages. A coefficient load request is
// mapped and stored in the cycle it is accepted and the unit is ready again
// the next cycle. A sample request runs the lattice on one shared multiplier,
// at most one product per cycle with the product registered and rounded,
// added and saturated in the following cycle. After the last slot of the
// schedule a flush state, which waits while the previous result has not been
// taken, moves the result into the output register; the unit then returns to
// idle and takes a new sample request. The filter mode must only be written
// while the unit is idle. Coefficients and the delay line reset to zero.
module short_term_lattice_filter_unit #(
    parameter int ORDER      = stlf_pkg::DEF_ORDER,
    parameter int DATA_WIDTH = stlf_pkg::DEF_DATA_WIDTH
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire                                 s_op,
    input  wire  [stlf_pkg::STAGE_W-1:0]        s_stage,
    input  wire  signed [stlf_pkg::IN_W-1:0]    s_data_in,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic signed [stlf_pkg::OUT_W-1:0]   m_data_out,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire                                 cfg_filter_mode
);

    localparam int DW     = DATA_WIDTH;
    localparam int CW     = stlf_pkg::COEF_W;
    localparam int PROD_W = CW + DW;
    localparam int EXT_W  = PROD_W + 1;
    localparam int IDX_W  = $clog2(ORDER);
    localparam int SLOT_W = $clog2(2 * ORDER + 1);
    localparam int OUT_W_L = stlf_pkg::OUT_W;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(2 * ORDER);
    localparam logic [SLOT_W-1:0] GAP_SLOT  = SLOT_W'(2 * ORDER - 2);
    localparam logic [SLOT_W-1:0] D0_SLOT   = SLOT_W'(2 * ORDER - 1);
    localparam logic [SLOT_W-1:0] TOP_IDX   = SLOT_W'(ORDER - 1);
    localparam logic [SLOT_W-1:0] NEXT_IDX  = SLOT_W'(ORDER - 2);
    localparam logic [SLOT_W-1:0] ORD_S     = SLOT_W'(ORDER);
    localparam logic [EXT_W-1:0]  RND_HALF  = EXT_W'(1) << (stlf_pkg::FRAC_BITS - 1);

    function automatic logic signed [DW-1:0] sat_dw(input logic signed [EXT_W-1:0] x);
        logic [EXT_W-DW:0] top;
        top = x[EXT_W-1:DW-1];
        if ((&top) || !(|top)) begin
            return x[DW-1:0];
        end
        return x[EXT_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    endfunction

    stlf_pkg::state_t    state_reg, state_next;
    stlf_pkg::mul_kind_t kind, pkind_reg;

    logic [SLOT_W-1:0]         slot_reg;
    logic                      filter_mode_reg;
    logic                      m_valid_reg;
    logic signed [OUT_W_L-1:0] m_data_reg;
    logic signed [CW-1:0]      coef_reg [ORDER];
    logic signed [DW-1:0]      delay_reg [ORDER];
    logic signed [DW-1:0]      acc_reg, carry_reg, old_reg;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [IDX_W-1:0]          idx, pidx_reg;
    logic [SLOT_W-1:0]         idx_wide;

    logic                      out_free, start, load, run, load_out, synth;
    logic signed [CW-1:0]      coef_rd;
    logic signed [DW-1:0]      dly_rd, opnd, sample_val, mr, base, cons;
    logic signed [EXT_W-1:0]   rnd_full, rnd, sum, mr_ext, base_ext, acc_ext;
    logic                      dly_we;
    logic [IDX_W-1:0]          dly_waddr;
    logic signed [DW-1:0]      dly_wdata;
    logic                      old_latch;

    assign synth     = (filter_mode_reg == stlf_pkg::MODE_SYNTHESIS);
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data_out = m_data_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stlf_pkg::ST_IDLE: begin
                if (s_valid && s_op == stlf_pkg::OP_SAMPLE) begin
                    state_next = stlf_pkg::ST_RUN;
                end
            end
            stlf_pkg::ST_RUN: begin
                if (slot_reg == LAST_SLOT) begin
                    state_next = stlf_pkg::ST_FLUSH;
                end
            end
            stlf_pkg::ST_FLUSH: begin
                if (out_free) begin
                    state_next = stlf_pkg::ST_IDLE;
                end
            end
            default: state_next = stlf_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready  = 1'b0;
        run      = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            stlf_pkg::ST_IDLE:  s_ready  = 1'b1;
            stlf_pkg::ST_RUN:   run      = 1'b1;
            stlf_pkg::ST_FLUSH: load_out = out_free;
            default: ;
        endcase
    end

    assign start = s_valid && s_ready && (s_op == stlf_pkg::OP_SAMPLE);
    assign load  = s_valid && s_ready && (s_op == stlf_pkg::OP_LOAD)
                   && (32'(s_stage) < ORDER);

    // slot schedule of the shared multiplier
    always_comb begin
        kind     = stlf_pkg::MK_NONE;
        idx_wide = '0;
        if (!synth) begin
            if (slot_reg < LAST_SLOT) begin
                kind     = slot_reg[0] ? stlf_pkg::MK_ACC : stlf_pkg::MK_DELAY;
                idx_wide = slot_reg >> 1;
            end
        end else begin
            if (slot_reg == '0) begin
                kind     = stlf_pkg::MK_DELAY;
                idx_wide = TOP_IDX;
            end else if (slot_reg == SLOT_W'(1)) begin
                kind     = stlf_pkg::MK_DELAY;
                idx_wide = NEXT_IDX;
            end else if (slot_reg == GAP_SLOT || slot_reg == LAST_SLOT) begin
                kind = stlf_pkg::MK_NONE;
            end else if (!slot_reg[0]) begin
                kind     = stlf_pkg::MK_DELAY;
                idx_wide = NEXT_IDX - (slot_reg >> 1);
            end else begin
                kind     = stlf_pkg::MK_ACC;
                idx_wide = ORD_S - ((slot_reg + SLOT_W'(1)) >> 1);
            end
        end
        if (!run) begin
            kind = stlf_pkg::MK_NONE;
        end
    end

    assign idx     = IDX_W'(idx_wide);
    assign coef_rd = coef_reg[idx];
    assign dly_rd  = delay_reg[idx];
    assign opnd    = (kind == stlf_pkg::MK_ACC) ? acc_reg : dly_rd;
    assign prod_next = coef_rd * opnd;

    assign old_latch = (kind == stlf_pkg::MK_DELAY && !synth)
                       || (kind == stlf_pkg::MK_ACC && synth);

    // round, saturate, then add or subtract and saturate again
    assign rnd_full = {prod_reg[PROD_W-1], prod_reg} + RND_HALF;
    assign rnd      = rnd_full >>> stlf_pkg::FRAC_BITS;
    assign mr       = sat_dw(rnd);
    assign base     = (pkind_reg == stlf_pkg::MK_DELAY) ? acc_reg : old_reg;
    assign mr_ext   = {{(EXT_W-DW){mr[DW-1]}}, mr};
    assign base_ext = {{(EXT_W-DW){base[DW-1]}}, base};
    assign sum      = (pkind_reg == stlf_pkg::MK_DELAY && synth) ? base_ext - mr_ext
                                                                  : base_ext + mr_ext;
    assign cons     = sat_dw(sum);

    assign sample_val = sat_dw({{(EXT_W-stlf_pkg::IN_W){s_data_in[stlf_pkg::IN_W-1]}},
                                s_data_in});
    assign acc_ext    = {{(EXT_W-DW){acc_reg[DW-1]}}, acc_reg};

    // single write port of the delay line
    always_comb begin
        dly_we    = 1'b0;
        dly_waddr = idx;
        dly_wdata = carry_reg;
        if (run) begin
            if (synth && pkind_reg == stlf_pkg::MK_ACC) begin
                dly_we    = 1'b1;
                dly_waddr = pidx_reg + IDX_W'(1);
                dly_wdata = cons;
            end else if (synth && slot_reg == D0_SLOT) begin
                dly_we    = 1'b1;
                dly_waddr = '0;
                dly_wdata = acc_reg;
            end else if (!synth && kind == stlf_pkg::MK_ACC) begin
                dly_we    = 1'b1;
                dly_waddr = idx;
                dly_wdata = carry_reg;
            end
        end
    end

    // control and stored state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= stlf_pkg::ST_IDLE;
            slot_reg        <= '0;
            filter_mode_reg <= stlf_pkg::MODE_ANALYSIS;
            m_valid_reg     <= 1'b0;
            pkind_reg       <= stlf_pkg::MK_NONE;
            for (int i = 0; i < ORDER; i++) begin
                coef_reg[i]  <= '0;
                delay_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            pkind_reg <= kind;
            if (start) begin
                slot_reg <= '0;
            end else if (run) begin
                slot_reg <= slot_reg + SLOT_W'(1);
            end
            if (cfg_valid && cfg_ready) begin
                filter_mode_reg <= cfg_filter_mode;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (load) begin
                coef_reg[IDX_W'(s_stage)] <= stlf_pkg::lar_to_coeff(s_data_in);
            end
            if (dly_we) begin
                delay_reg[dly_waddr] <= dly_wdata;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        pidx_reg <= idx;
        if (old_latch) begin
            old_reg <= dly_rd;
        end
        if (start) begin
            acc_reg   <= sample_val;
            carry_reg <= sample_val;
        end else if (run) begin
            if (pkind_reg == stlf_pkg::MK_DELAY) begin
                acc_reg <= cons;
            end else if (pkind_reg == stlf_pkg::MK_ACC && !synth) begin
                carry_reg <= cons;
            end
        end
        if (load_out) begin
            m_data_reg <= acc_ext[OUT_W_L-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== sv/stlf_checker.sv =====
// stlf_checker: port-level checks of the short-term lattice filter unit
// depends on stlf_pkg, bound to short_term_lattice_filter_unit
`default_nettype none

module stlf_checker (
    input wire                              aclk,
    input wire                              aresetn,
    input wire                              s_valid,
    input wire                              s_ready,
    input wire                              s_op,
    input wire                              m_valid,
    input wire                              m_ready,
    input wire [stlf_pkg::OUT_W-1:0]        m_data_out
);

    // a sample request keeps the unit busy
    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == stlf_pkg::OP_SAMPLE |=> !s_ready)
        else $error("ready after sample request");

    // a coefficient load finishes at once
    a_load_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == stlf_pkg::OP_LOAD |=> s_ready)
        else $error("not ready after load request");

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_out))
        else $error("result dropped or changed while stalled");

    // a new result only comes out of a busy period
    a_out_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared while idle");

endmodule

bind short_term_lattice_filter_unit stlf_checker u_stlf_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_op       (s_op),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_data_out (m_data_out)
);

`default_nettype wire
